>>> design/apcf_pkg.sv
package apcf_pkg;

	// Command codes carried on the cmd field
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	// Filter values for the class and instruction bytes
	localparam logic [7:0] CLA_REJECT   = 8'hFF;
	localparam logic [3:0] INS_REJECT_A = 4'h6;
	localparam logic [3:0] INS_REJECT_B = 4'h9;

	// Most bytes one item can produce
	localparam int unsigned JOB_BYTES = 7;
	localparam int unsigned JOB_IDX_W = $clog2(JOB_BYTES);
	localparam int unsigned JOB_CNT_W = $clog2(JOB_BYTES + 1);

	// Depth of the job queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// One classified item: the bytes it emits, how many, and whether it closes the APDU
	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] bytes;
		logic [JOB_CNT_W-1:0]      count;
		logic                      apdu_last;
	} job_t;

	// Encoded Le field, zero to three bytes
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      count;
	} le_field_t;

	// Build the Le field for a response length
	function automatic le_field_t build_le(input logic [16:0] le, input logic ext);
		le_field_t f;
		f = '0;
		if (le != 17'd0) begin
			if (ext) begin
				if (!le[16]) begin
					f.bytes[0] = 8'h00;
					f.bytes[1] = le[15:8];
					f.bytes[2] = le[7:0];
					f.count    = 2'd3;
				end else if (le[15:0] == 16'd0) begin
					f.count = 2'd2;
				end
			end else begin
				f.bytes[0] = le[7:0];
				f.count    = 2'd1;
			end
		end
		return f;
	endfunction

endpackage

>>> design/apcf_front.sv
module apcf_front import apcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [7:0]  class_byte,
	input  logic [7:0]  instr_byte,
	input  logic [7:0]  param_one,
	input  logic [7:0]  param_two,
	input  logic [15:0] data_length,
	input  logic [16:0] max_response,
	input  logic [7:0]  data_byte,
	input  logic        q_full,
	output logic        q_push,
	output job_t        q_job
);

	logic        extended_mode_q;
	logic [7:0]  kept_class_q;
	logic [7:0]  kept_instr_q;
	logic [15:0] bytes_left_q;
	logic [16:0] pending_le_q;

	logic        accept;
	logic [7:0]  class_nxt;
	logic [7:0]  instr_nxt;
	logic [15:0] bytes_left_nxt;
	logic [16:0] pending_le_nxt;
	logic [15:0] left_dec;
	le_field_t   le_f;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign left_dec = bytes_left_q - 16'd1;

	// Classify the item and build its byte job
	always_comb begin
		class_nxt      = (class_byte != CLA_REJECT) ? class_byte : kept_class_q;
		instr_nxt      = (instr_byte[7:4] == INS_REJECT_A || instr_byte[7:4] == INS_REJECT_B)
			? kept_instr_q : instr_byte;
		bytes_left_nxt = bytes_left_q;
		pending_le_nxt = pending_le_q;
		q_job          = '0;
		q_push         = 1'b0;
		le_f           = '0;
		if (cmd == CMD_START) begin
			q_push         = accept;
			q_job.bytes[0] = class_nxt;
			q_job.bytes[1] = instr_nxt;
			q_job.bytes[2] = param_one;
			q_job.bytes[3] = param_two;
			bytes_left_nxt = data_length;
			if (data_length != 16'd0) begin
				pending_le_nxt = max_response;
				if (extended_mode_q) begin
					q_job.bytes[4] = 8'h00;
					q_job.bytes[5] = data_length[15:8];
					q_job.bytes[6] = data_length[7:0];
					q_job.count    = JOB_CNT_W'(7);
				end else begin
					q_job.bytes[4] = data_length[7:0];
					q_job.count    = JOB_CNT_W'(5);
				end
			end else begin
				pending_le_nxt  = 17'd0;
				le_f            = build_le(max_response, extended_mode_q);
				q_job.bytes[4]  = le_f.bytes[0];
				q_job.bytes[5]  = le_f.bytes[1];
				q_job.bytes[6]  = le_f.bytes[2];
				q_job.count     = JOB_CNT_W'(4) + JOB_CNT_W'(le_f.count);
				q_job.apdu_last = 1'b1;
			end
		end else if (bytes_left_q != 16'd0) begin
			q_push         = accept;
			q_job.bytes[0] = data_byte;
			bytes_left_nxt = left_dec;
			q_job.count    = JOB_CNT_W'(1);
			if (left_dec == 16'd0) begin
				pending_le_nxt  = 17'd0;
				le_f            = build_le(pending_le_q, extended_mode_q);
				q_job.bytes[1]  = le_f.bytes[0];
				q_job.bytes[2]  = le_f.bytes[1];
				q_job.bytes[3]  = le_f.bytes[2];
				q_job.count     = JOB_CNT_W'(1) + JOB_CNT_W'(le_f.count);
				q_job.apdu_last = 1'b1;
			end
		end
	end

	// Hold the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extended_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			extended_mode_q <= cfg_wr_data;
		end
	end

	// Advance command state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_class_q <= 8'h00;
			kept_instr_q <= 8'h00;
			bytes_left_q <= 16'd0;
			pending_le_q <= 17'd0;
		end else if (accept) begin
			if (cmd == CMD_START) begin
				kept_class_q <= class_nxt;
				kept_instr_q <= instr_nxt;
			end
			bytes_left_q <= bytes_left_nxt;
			pending_le_q <= pending_le_nxt;
		end
	end

endmodule

>>> design/apcf_queue.sv
module apcf_queue import apcf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t head_job
);

	job_t                   entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign full     = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign head_job = entry_q[rd_ptr_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/apcf_back.sv
module apcf_back import apcf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  job_t       q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       item_end,
	output logic       apdu_end
);

	logic [JOB_IDX_W-1:0] idx_q;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 item_end_q;
	logic                 apdu_end_q;

	logic advance;
	logic load;
	logic last_byte;

	assign advance   = !out_valid_q || !out_stall;
	assign load      = advance && !q_empty;
	assign last_byte = (JOB_CNT_W'(idx_q) + JOB_CNT_W'(1)) == q_head.count;
	assign q_pop     = load && last_byte;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign item_end  = item_end_q;
	assign apdu_end  = apdu_end_q;

	// Step through the head job one byte per cycle while the output is not stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= !q_empty;
			if (load) begin
				idx_q <= last_byte ? '0 : idx_q + 1'b1;
			end
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= q_head.bytes[idx_q];
			item_end_q <= last_byte;
			apdu_end_q <= last_byte && q_head.apdu_last;
		end
	end

endmodule

>>> design/apdu_command_framer_unit.sv
// An accepted item is written into the job queue; its first byte is then loaded into
// the serializer's output register and offered, once any stalled byte there has left.
// Throughput: one item per cycle while each item yields one byte and no output stall;
// the serializer emits an item's bytes (up to seven) one per cycle while not stalled.
// Input stalls only when the two-entry job queue is full.
// Reset: arst_n clears the mode register, kept bytes, counters and queue.
module apdu_command_framer_unit import apcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [7:0]  class_byte,
	input  logic [7:0]  instr_byte,
	input  logic [7:0]  param_one,
	input  logic [7:0]  param_two,
	input  logic [15:0] data_length,
	input  logic [16:0] max_response,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        item_end,
	output logic        apdu_end
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t push_job;
	job_t head_job;

	// Classify items into byte jobs
	apcf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.class_byte   (class_byte),
		.instr_byte   (instr_byte),
		.param_one    (param_one),
		.param_two    (param_two),
		.data_length  (data_length),
		.max_response (max_response),
		.data_byte    (data_byte),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_job        (push_job)
	);

	// Buffer jobs between front and back
	apcf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head_job (head_job)
	);

	// Serialize jobs onto the byte stream
	apcf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (head_job),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.item_end  (item_end),
		.apdu_end  (apdu_end)
	);

endmodule
